// ===== src/xtea_pkg.sv =====
`default_nettype none
package xtea_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CNT_W    = 9;
	localparam int unsigned KEY_N    = 4;
	localparam int unsigned KSEL_W   = 2;
	localparam int unsigned KSEL_LO  = 11;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned RIDX_W   = 3;

	localparam logic [WORD_W-1:0] DELTA       = 32'h9E37_79B9;
	localparam logic [CNT_W-1:0]  CNT_RESET   = 9'd256;

	localparam logic [RIDX_W-1:0] REG_KEY0  = 3'd0;
	localparam logic [RIDX_W-1:0] REG_KEY1  = 3'd1;
	localparam logic [RIDX_W-1:0] REG_KEY2  = 3'd2;
	localparam logic [RIDX_W-1:0] REG_KEY3  = 3'd3;
	localparam logic [RIDX_W-1:0] REG_COUNT = 3'd4;

	typedef logic [KEY_N-1:0][WORD_W-1:0] key_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HALF_B,
		ST_HALF_A,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step_b;
		logic step_a;
		logic emit;
	} dp_cmd_t;

	function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] w);
		mix = ((w << 4) ^ (w >> 5)) + w;
	endfunction

endpackage
`default_nettype wire

// ===== src/xtea_block_decipher_top.sv =====
// Channel  Handshake            Beat
// in       in_valid/in_ready    cipher_first, cipher_second
// out      out_valid/out_ready  plain_first, plain_second
// cfg      APB psel/penable     key_word0..3, cycle_count at 4*i
//
// A block runs one Feistel half-round per clock through the single round unit.
// The input is taken only while no block is in the round unit.
// A finished result waits in the output register while the next block runs.
// Reset clears the key to zero and sets the cycle count to 256.
`default_nettype none
module xtea_block_decipher_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [xtea_pkg::WORD_W-1:0] cipher_first,
	input  wire logic [xtea_pkg::WORD_W-1:0] cipher_second,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [xtea_pkg::WORD_W-1:0]      plain_first,
	output logic [xtea_pkg::WORD_W-1:0]      plain_second,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [xtea_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import xtea_pkg::*;

	key_t             key;
	logic [CNT_W-1:0] cycle_count;
	dp_cmd_t          cmd;

	xtea_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.key         (key),
		.cycle_count (cycle_count)
	);

	xtea_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cycle_count (cycle_count),
		.cmd         (cmd)
	);

	xtea_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.key           (key),
		.cycle_count   (cycle_count),
		.cipher_first  (cipher_first),
		.cipher_second (cipher_second),
		.plain_first   (plain_first),
		.plain_second  (plain_second)
	);
endmodule
`default_nettype wire

// ===== src/xtea_regs.sv =====
`default_nettype none
module xtea_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [xtea_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output xtea_pkg::key_t                   key,
	output logic [xtea_pkg::CNT_W-1:0]       cycle_count
);
	import xtea_pkg::*;

	key_t             key_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic [RIDX_W-1:0] ridx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign ridx   = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			count_q <= CNT_RESET;
		end else if (wr_en) begin
			unique case (ridx)
				REG_KEY0:  key_q[0] <= pwdata;
				REG_KEY1:  key_q[1] <= pwdata;
				REG_KEY2:  key_q[2] <= pwdata;
				REG_KEY3:  key_q[3] <= pwdata;
				REG_COUNT: count_q  <= pwdata[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_KEY0:  prdata = key_q[0];
			REG_KEY1:  prdata = key_q[1];
			REG_KEY2:  prdata = key_q[2];
			REG_KEY3:  prdata = key_q[3];
			REG_COUNT: prdata = 32'(count_q);
			default:   prdata = '0;
		endcase
	end

	assign key         = key_q;
	assign cycle_count = count_q;
endmodule
`default_nettype wire

// ===== src/xtea_ctrl.sv =====
`default_nettype none
module xtea_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	input  wire logic [xtea_pkg::CNT_W-1:0]  cycle_count,
	output xtea_pkg::dp_cmd_t                cmd
);
	import xtea_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last_round;

	assign out_free   = !out_valid_q || out_ready;
	assign last_round = (cnt_q == CNT_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (cycle_count == '0) ? ST_FINISH : ST_HALF_B;
				end
			end
			ST_HALF_B: state_d = ST_HALF_A;
			ST_HALF_A: state_d = last_round ? ST_FINISH : ST_HALF_B;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_HALF_B: cmd.step_b = 1'b1;
			ST_HALF_A: cmd.step_a = 1'b1;
			ST_FINISH: cmd.emit   = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= cycle_count;
			end else if (cmd.step_a) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== src/xtea_dp.sv =====
`default_nettype none
module xtea_dp (
	input  wire logic                         clk,
	input  wire xtea_pkg::dp_cmd_t            cmd,
	input  wire xtea_pkg::key_t               key,
	input  wire logic [xtea_pkg::CNT_W-1:0]   cycle_count,
	input  wire logic [xtea_pkg::WORD_W-1:0]  cipher_first,
	input  wire logic [xtea_pkg::WORD_W-1:0]  cipher_second,
	output logic [xtea_pkg::WORD_W-1:0]       plain_first,
	output logic [xtea_pkg::WORD_W-1:0]       plain_second
);
	import xtea_pkg::*;

	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] sum_q;
	logic [WORD_W-1:0] pa_q;
	logic [WORD_W-1:0] pb_q;
	logic [WORD_W-1:0] start_sum;
	logic [WORD_W-1:0] b_next;
	logic [WORD_W-1:0] a_next;

	assign start_sum = DELTA * WORD_W'(cycle_count);
	assign b_next = b_q - (mix(a_q) ^ (sum_q + key[sum_q[KSEL_LO+KSEL_W-1:KSEL_LO]]));
	assign a_next = a_q - (mix(b_q) ^ (sum_q + key[sum_q[KSEL_W-1:0]]));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= cipher_first;
			b_q   <= cipher_second;
			sum_q <= start_sum;
		end else if (cmd.step_b) begin
			b_q   <= b_next;
			sum_q <= sum_q - DELTA;
		end else if (cmd.step_a) begin
			a_q <= a_next;
		end
		if (cmd.emit) begin
			pa_q <= a_q;
			pb_q <= b_q;
		end
	end

	assign plain_first  = pa_q;
	assign plain_second = pb_q;
endmodule
`default_nettype wire

// ===== src/xtea_chk.sv =====
`default_nettype none
module xtea_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] plain_first,
	input wire logic [31:0] plain_second,
	input wire logic        pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(plain_first) && $stable(plain_second))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a block is in flight");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after input beat");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind xtea_block_decipher_top xtea_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.plain_first  (plain_first),
	.plain_second (plain_second),
	.pready       (pready)
);
`default_nettype wire
